### design/tfn_pkg.sv
`default_nettype none
package tfn_pkg;

   // field and datapath widths
   localparam int CoordW = 32;
   localparam int EdgeW  = 33;
   localparam int ProdW  = 66;
   localparam int CrossW = 67;
   localparam int MagW   = 65;
   localparam int LenW   = 7;
   localparam int MantW  = 30;
   localparam int SqW    = 60;
   localparam int SumW   = 62;
   localparam int RootW  = 31;
   localparam int QW     = 15;
   localparam int OutW   = 16;
   localparam int NumW   = 46;
   localparam int DenW   = 32;

   // side data carried through the square-root pipeline
   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [2:0]       neg;
      logic [MantW-1:0] r_x;
      logic [MantW-1:0] r_y;
      logic [MantW-1:0] r_z;
   } sqrt_tag_type;

   // side data carried through the divider pipeline
   typedef struct packed {
      logic       valid;
      logic       degen;
      logic [2:0] neg;
   } div_tag_type;

endpackage
`default_nettype wire

### design/tfn_isqrt.sv
`default_nettype none
module tfn_isqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic [tfn_pkg::SumW-1:0]    sum_sq,
   input  wire tfn_pkg::sqrt_tag_type       tag_in,
   output logic [tfn_pkg::RootW-1:0]        root,
   output tfn_pkg::sqrt_tag_type            tag_out
);
   localparam int Steps = tfn_pkg::RootW;
   localparam int RemW  = 35;

   logic [RemW-1:0]           rem_ff  [Steps];
   logic [tfn_pkg::SumW-1:0]  rad_ff  [Steps];
   logic [tfn_pkg::RootW-1:0] root_ff [Steps];
   tfn_pkg::sqrt_tag_type     tag_ff  [Steps];

   // one root bit per stage, two radicand bits shifted in each time
   for (genvar g = 0; g < Steps; g++) begin : g_step
      logic [RemW-1:0]           rem_prev;
      logic [tfn_pkg::SumW-1:0]  rad_prev;
      logic [tfn_pkg::RootW-1:0] root_prev;
      tfn_pkg::sqrt_tag_type     tag_prev;
      logic [RemW-1:0]           rem_try;
      logic [RemW-1:0]           trial;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = sum_sq;
         assign root_prev = '0;
         assign tag_prev  = tag_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign tag_prev  = tag_ff[g-1];
      end

      assign rem_try = {rem_prev[RemW-3:0], rad_prev[tfn_pkg::SumW-1 -: 2]};
      assign trial   = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g] <= '0;
         end else if (en) begin
            tag_ff[g] <= tag_prev;
            rad_ff[g] <= rad_prev << 2;
            if (rem_try >= trial) begin
               rem_ff[g]  <= rem_try - trial;
               root_ff[g] <= {root_prev[tfn_pkg::RootW-2:0], 1'b1};
            end else begin
               rem_ff[g]  <= rem_try;
               root_ff[g] <= {root_prev[tfn_pkg::RootW-2:0], 1'b0};
            end
         end
      end
   end

   assign root    = root_ff[Steps-1];
   assign tag_out = tag_ff[Steps-1];

endmodule
`default_nettype wire

### design/tfn_qdiv.sv
`default_nettype none
module tfn_qdiv (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic [tfn_pkg::MantW-1:0]   r_x,
   input  wire logic [tfn_pkg::MantW-1:0]   r_y,
   input  wire logic [tfn_pkg::MantW-1:0]   r_z,
   input  wire logic [tfn_pkg::RootW-1:0]   len,
   input  wire tfn_pkg::div_tag_type        tag_in,
   output logic [tfn_pkg::QW-1:0]           q_x,
   output logic [tfn_pkg::QW-1:0]           q_y,
   output logic [tfn_pkg::QW-1:0]           q_z,
   output tfn_pkg::div_tag_type             tag_out
);
   localparam int Steps = tfn_pkg::QW;

   logic [tfn_pkg::NumW-1:0] num_ff [Steps][3];
   logic [tfn_pkg::QW-1:0]   q_ff   [Steps][3];
   logic [tfn_pkg::DenW-1:0] den_ff [Steps];
   tfn_pkg::div_tag_type     tag_ff [Steps];

   // rounded numerator r*2^15 + len over 2*len
   logic [tfn_pkg::NumW-1:0] num_init [3];
   logic [tfn_pkg::DenW-1:0] den_init;
   assign num_init[0] = tfn_pkg::NumW'({r_x, 15'b0}) + tfn_pkg::NumW'(len);
   assign num_init[1] = tfn_pkg::NumW'({r_y, 15'b0}) + tfn_pkg::NumW'(len);
   assign num_init[2] = tfn_pkg::NumW'({r_z, 15'b0}) + tfn_pkg::NumW'(len);
   assign den_init    = {len, 1'b0};

   // restoring division, one quotient bit per stage, msb first
   for (genvar g = 0; g < Steps; g++) begin : g_step
      logic [tfn_pkg::NumW-1:0] num_prev [3];
      logic [tfn_pkg::QW-1:0]   q_prev   [3];
      logic [tfn_pkg::DenW-1:0] den_prev;
      tfn_pkg::div_tag_type     tag_prev;
      logic [tfn_pkg::NumW-1:0] den_sh;

      if (g == 0) begin : g_first
         assign num_prev = num_init;
         assign q_prev   = '{default: '0};
         assign den_prev = den_init;
         assign tag_prev = tag_in;
      end else begin : g_next
         assign num_prev = num_ff[g-1];
         assign q_prev   = q_ff[g-1];
         assign den_prev = den_ff[g-1];
         assign tag_prev = tag_ff[g-1];
      end

      assign den_sh = tfn_pkg::NumW'(den_prev) << (Steps - 1 - g);

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g] <= '0;
         end else if (en) begin
            tag_ff[g] <= tag_prev;
            den_ff[g] <= den_prev;
            for (int c = 0; c < 3; c++) begin
               if (num_prev[c] >= den_sh) begin
                  num_ff[g][c] <= num_prev[c] - den_sh;
                  q_ff[g][c]   <= {q_prev[c][tfn_pkg::QW-2:0], 1'b1};
               end else begin
                  num_ff[g][c] <= num_prev[c];
                  q_ff[g][c]   <= {q_prev[c][tfn_pkg::QW-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign q_x     = q_ff[Steps-1][0];
   assign q_y     = q_ff[Steps-1][1];
   assign q_z     = q_ff[Steps-1][2];
   assign tag_out = tag_ff[Steps-1];

endmodule
`default_nettype wire

### design/triangle_face_normal.sv
`default_nettype none
// Unit face normal of a triangle. Corners come in as signed Q16.16, the normal
// of (b-a) x (c-a) goes out as signed Q1.14, rounded half away from zero; a
// zero cross product gives the zero vector with degenerate set. One triangle
// is taken every clock cycle while req_stall is low. The datapath is built
// mostly from the 31-stage square-root pipeline (one root bit per stage)
// and the 15-stage divider (one quotient bit per stage). A two-entry output
// buffer keeps the pipeline moving while one result waits; req_stall rises
// only when both are full, and then the whole pipeline holds.
module triangle_face_normal (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_a_x,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_a_y,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_a_z,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_b_x,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_b_y,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_b_z,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_c_x,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_c_y,
   input  wire logic signed [tfn_pkg::CoordW-1:0] req_c_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [tfn_pkg::OutW-1:0]        rsp_normal_x,
   output logic signed [tfn_pkg::OutW-1:0]        rsp_normal_y,
   output logic signed [tfn_pkg::OutW-1:0]        rsp_normal_z,
   output logic                                   rsp_degenerate
);
   localparam int EdgeW  = tfn_pkg::EdgeW;
   localparam int ProdW  = tfn_pkg::ProdW;
   localparam int CrossW = tfn_pkg::CrossW;
   localparam int MagW   = tfn_pkg::MagW;
   localparam int LenW   = tfn_pkg::LenW;
   localparam int MantW  = tfn_pkg::MantW;
   localparam int OutW   = tfn_pkg::OutW;

   logic en;
   logic skid_valid_ff, skid_valid_in;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: edges
   logic signed [EdgeW-1:0] e_ff [6];
   logic                    v1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff   <= req_valid;
         e_ff[0] <= EdgeW'(req_b_x) - EdgeW'(req_a_x);
         e_ff[1] <= EdgeW'(req_b_y) - EdgeW'(req_a_y);
         e_ff[2] <= EdgeW'(req_b_z) - EdgeW'(req_a_z);
         e_ff[3] <= EdgeW'(req_c_x) - EdgeW'(req_a_x);
         e_ff[4] <= EdgeW'(req_c_y) - EdgeW'(req_a_y);
         e_ff[5] <= EdgeW'(req_c_z) - EdgeW'(req_a_z);
      end
   end

   // stage 2: six partial products
   logic signed [ProdW-1:0] p_ff [6];
   logic                    v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff   <= v1_ff;
         p_ff[0] <= e_ff[1] * e_ff[5];
         p_ff[1] <= e_ff[2] * e_ff[4];
         p_ff[2] <= e_ff[2] * e_ff[3];
         p_ff[3] <= e_ff[0] * e_ff[5];
         p_ff[4] <= e_ff[0] * e_ff[4];
         p_ff[5] <= e_ff[1] * e_ff[3];
      end
   end

   // stage 3: cross product
   logic signed [CrossW-1:0] n_ff [3];
   logic                     v3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
         for (int c = 0; c < 3; c++) begin
            n_ff[c] <= CrossW'(p_ff[2*c]) - CrossW'(p_ff[2*c+1]);
         end
      end
   end

   // stage 4: sign and magnitude
   logic [MagW-1:0] m_ff [3];
   logic [2:0]      neg4_ff;
   logic            v4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
         for (int c = 0; c < 3; c++) begin
            neg4_ff[c] <= n_ff[c][CrossW-1];
            m_ff[c]    <= n_ff[c][CrossW-1] ? MagW'(-n_ff[c]) : MagW'(n_ff[c]);
         end
      end
   end

   // stage 5: bit length of the largest magnitude
   logic [MagW-1:0] m_or;
   logic [LenW-1:0] k_in;
   assign m_or = m_ff[0] | m_ff[1] | m_ff[2];
   always_comb begin
      k_in = '0;
      for (int i = 0; i < MagW; i++) begin
         if (m_or[i]) k_in = LenW'(i + 1);
      end
   end

   logic [MagW-1:0] m5_ff [3];
   logic [LenW-1:0] k_ff;
   logic [2:0]      neg5_ff;
   logic            v5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff   <= v4_ff;
         m5_ff   <= m_ff;
         k_ff    <= k_in;
         neg5_ff <= neg4_ff;
      end
   end

   // stage 6: scale to a 30-bit mantissa
   logic [MantW-1:0] r_ff [3];
   logic [2:0]       neg6_ff;
   logic             degen6_ff;
   logic             v6_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff     <= v5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= (k_ff == '0);
         for (int c = 0; c < 3; c++) begin
            if (k_ff > LenW'(MantW)) begin
               r_ff[c] <= MantW'(m5_ff[c] >> (k_ff - LenW'(MantW)));
            end else begin
               r_ff[c] <= MantW'(m5_ff[c] << (LenW'(MantW) - k_ff));
            end
         end
      end
   end

   // stage 7: squares
   logic [tfn_pkg::SqW-1:0] sq_ff [3];
   tfn_pkg::sqrt_tag_type   tag7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tag7_ff <= '0;
      end else if (en) begin
         tag7_ff <= '{valid: v6_ff, degen: degen6_ff, neg: neg6_ff,
                      r_x: r_ff[0], r_y: r_ff[1], r_z: r_ff[2]};
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= tfn_pkg::SqW'(r_ff[c]) * tfn_pkg::SqW'(r_ff[c]);
         end
      end
   end

   // stage 8: sum of squares
   logic [tfn_pkg::SumW-1:0] sum_ff;
   tfn_pkg::sqrt_tag_type    tag8_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tag8_ff <= '0;
      end else if (en) begin
         tag8_ff <= tag7_ff;
         sum_ff  <= tfn_pkg::SumW'(sq_ff[0]) + tfn_pkg::SumW'(sq_ff[1])
                    + tfn_pkg::SumW'(sq_ff[2]);
      end
   end

   // length
   logic [tfn_pkg::RootW-1:0] len;
   tfn_pkg::sqrt_tag_type     sq_tag;
   tfn_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .sum_sq  (sum_ff),
      .tag_in  (tag8_ff),
      .root    (len),
      .tag_out (sq_tag)
   );

   // component over length
   tfn_pkg::div_tag_type    div_tag_in, div_tag;
   logic [tfn_pkg::QW-1:0]  q_x, q_y, q_z;
   assign div_tag_in = '{valid: sq_tag.valid, degen: sq_tag.degen, neg: sq_tag.neg};
   tfn_qdiv u_qdiv (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .r_x     (sq_tag.r_x),
      .r_y     (sq_tag.r_y),
      .r_z     (sq_tag.r_z),
      .len     (len),
      .tag_in  (div_tag_in),
      .q_x     (q_x),
      .q_y     (q_y),
      .q_z     (q_z),
      .tag_out (div_tag)
   );

   // sign applied, zero vector for a degenerate triangle
   logic [OutW-1:0] fin_x, fin_y, fin_z;
   logic [OutW-1:0] mag_x, mag_y, mag_z;
   assign mag_x = {1'b0, q_x};
   assign mag_y = {1'b0, q_y};
   assign mag_z = {1'b0, q_z};
   assign fin_x = div_tag.degen ? '0 : (div_tag.neg[0] ? -mag_x : mag_x);
   assign fin_y = div_tag.degen ? '0 : (div_tag.neg[1] ? -mag_y : mag_y);
   assign fin_z = div_tag.degen ? '0 : (div_tag.neg[2] ? -mag_z : mag_z);

   // output register with one skid entry behind it
   logic            out_valid_ff, out_valid_in;
   logic [OutW-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic            out_degen_ff;
   logic [OutW-1:0] skid_x_ff, skid_y_ff, skid_z_ff;
   logic            skid_degen_ff;
   logic            take;
   logic            push;
   logic            load_out;
   logic            load_skid;

   assign take      = out_valid_ff && !rsp_stall;
   assign push      = en && div_tag.valid;
   assign load_out  = push && (!out_valid_ff || take);
   assign load_skid = push && out_valid_ff && !take;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) skid_valid_in = 1'b0;
      end else if (load_out) begin
         out_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b1;
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && take) begin
         out_x_ff     <= skid_x_ff;
         out_y_ff     <= skid_y_ff;
         out_z_ff     <= skid_z_ff;
         out_degen_ff <= skid_degen_ff;
      end else if (!skid_valid_ff && load_out) begin
         out_x_ff     <= fin_x;
         out_y_ff     <= fin_y;
         out_z_ff     <= fin_z;
         out_degen_ff <= div_tag.degen;
      end
      if (!skid_valid_ff && load_skid) begin
         skid_x_ff     <= fin_x;
         skid_y_ff     <= fin_y;
         skid_z_ff     <= fin_z;
         skid_degen_ff <= div_tag.degen;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_normal_x   = out_x_ff;
   assign rsp_normal_y   = out_y_ff;
   assign rsp_normal_z   = out_z_ff;
   assign rsp_degenerate = out_degen_ff;

   // checks
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate item with non-zero normal");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384 &&
         rsp_normal_y >= -16'sd16384 && rsp_normal_y <= 16'sd16384 &&
         rsp_normal_z >= -16'sd16384 && rsp_normal_z <= 16'sd16384)
      else $error("normal component out of unit range");

endmodule
`default_nettype wire

### verif/triangle_face_normal_test.sv
`default_nettype none
module triangle_face_normal_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [tfn_pkg::CoordW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } corners_type;

   typedef struct packed {
      logic signed [tfn_pkg::OutW-1:0] nx, ny, nz;
      logic                            degen;
   } normal_type;

   typedef struct {
      corners_type tri_in;
      bit          typed;
      normal_type  want;
   } stim_row_type;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 120;
   localparam int HoldLength    = 300;
   localparam int Q14One        = 16384;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [tfn_pkg::CoordW-1:0] req_a_x, req_a_y, req_a_z;
   logic signed [tfn_pkg::CoordW-1:0] req_b_x, req_b_y, req_b_z;
   logic signed [tfn_pkg::CoordW-1:0] req_c_x, req_c_y, req_c_z;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [tfn_pkg::OutW-1:0]   rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic                              rsp_degenerate;

   normal_type   expected_normals[$];
   stim_row_type stim_table[$];
   int           send_idle_pct;
   int           recv_stall_pct;
   bit           hold_start;
   bit           hold_taken;
   int           hold_cycles;
   int           mismatches;
   int           items_sent;
   int           normals_seen;
   int           degen_seen;
   int           quiet_cycles;

   triangle_face_normal uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_c_z(req_c_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // integer square root, floor
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // unit normal of (b-a) x (c-a) in Q1.14
   function automatic normal_type face_normal(corners_type t);
      logic signed [tfn_pkg::CrossW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
      logic signed [tfn_pkg::CrossW-1:0] cr[3];
      logic [tfn_pkg::CrossW-1:0]        mag[3];
      logic [tfn_pkg::CrossW-1:0]        scaled;
      longint unsigned                   r[3];
      longint unsigned                   sum, len, q;
      int                                k;
      normal_type                        n;
      logic [tfn_pkg::OutW-1:0]          comp[3];
      e1x = t.bx - t.ax; e1y = t.by - t.ay; e1z = t.bz - t.az;
      e2x = t.cx - t.ax; e2y = t.cy - t.ay; e2z = t.cz - t.az;
      cr[0] = e1y * e2z - e1z * e2y;
      cr[1] = e1z * e2x - e1x * e2z;
      cr[2] = e1x * e2y - e1y * e2x;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
         for (int b = tfn_pkg::CrossW - 1; b >= 0; b--) begin
            if (mag[i][b] && b + 1 > k) k = b + 1;
         end
      end
      if (k == 0) begin
         n = '0;
         n.degen = 1'b1;
         return n;
      end
      // scale so the largest magnitude has exactly MantW bits
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (k > tfn_pkg::MantW) scaled = mag[i] >> (k - tfn_pkg::MantW);
         else scaled = mag[i] << (tfn_pkg::MantW - k);
         r[i] = 64'(scaled[tfn_pkg::MantW-1:0]);
         sum += r[i] * r[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (2 * r[i] * Q14One + len) / (2 * len);
         comp[i] = cr[i] < 0 ? -q[tfn_pkg::OutW-1:0] : q[tfn_pkg::OutW-1:0];
      end
      n.nx = comp[0];
      n.ny = comp[1];
      n.nz = comp[2];
      n.degen = 1'b0;
      return n;
   endfunction

   function automatic logic signed [tfn_pkg::CoordW-1:0] rand_word();
      return $urandom();
   endfunction

   function automatic logic signed [tfn_pkg::CoordW-1:0] rand_near(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // random triangle: full range, small, collinear or repeated corner
   function automatic corners_type rand_triangle();
      corners_type t;
      int          mode, span, mult;
      mode = $urandom_range(99);
      if (mode < 50) begin
         t = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word()};
      end else if (mode < 80) begin
         span = 1 << $urandom_range(20);
         t = {rand_near(span), rand_near(span), rand_near(span), rand_near(span),
              rand_near(span), rand_near(span), rand_near(span), rand_near(span),
              rand_near(span)};
      end else if (mode < 92) begin
         // collinear corners give a zero cross product
         mult = $signed($urandom_range(6)) - 3;
         t.ax = rand_near(1 << 24); t.ay = rand_near(1 << 24); t.az = rand_near(1 << 24);
         t.bx = t.ax + rand_near(1 << 20);
         t.by = t.ay + rand_near(1 << 20);
         t.bz = t.az + rand_near(1 << 20);
         t.cx = t.ax + mult * (t.bx - t.ax);
         t.cy = t.ay + mult * (t.by - t.ay);
         t.cz = t.az + mult * (t.bz - t.az);
      end else begin
         // repeated corner
         t = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word()};
         t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
      end
      return t;
   endfunction

   function automatic void add_row(corners_type t, bit typed, normal_type want);
      stim_row_type row;
      row.tri_in = t;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   // directed triangles; the obvious ones carry their normal
   function automatic void build_table();
      localparam logic signed [tfn_pkg::CoordW-1:0] One = 32'sh0001_0000;
      localparam logic signed [tfn_pkg::CoordW-1:0] Mx = 32'sh7fff_ffff;
      localparam logic signed [tfn_pkg::CoordW-1:0] Mn = 32'sh8000_0000;
      add_row('0, 1, '{0, 0, 0, 1});
      add_row({9{32'sh1234_5678}}, 1, '{0, 0, 0, 1});
      add_row({Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx}, 1, '{0, 0, 0, 1});
      add_row({Mn, Mn, Mn, Mx, Mx, Mx, Mx, Mx, Mx}, 1, '{0, 0, 0, 1});
      add_row({32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One, 32'sd0},
              1, '{0, 0, Q14One, 0});
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd0, One, 32'sd0, One, 32'sd0, 32'sd0},
              1, '{0, 0, -Q14One, 0});
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd0, One, 32'sd0, 32'sd0, 32'sd0, One},
              1, '{Q14One, 0, 0, 0});
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, One, One, 32'sd0, 32'sd0},
              1, '{0, Q14One, 0, 0});
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0},
              1, '{0, 0, Q14One, 0});
      add_row({Mn, Mn, Mn, Mx, Mn, Mn, Mn, Mx, Mn}, 1, '{0, 0, Q14One, 0});
      add_row({Mx, Mx, Mx, Mn, Mx, Mx, Mx, Mn, Mx}, 1, '{0, 0, Q14One, 0});
      add_row({Mn, Mn, Mn, Mx, Mx, Mn, Mn, Mx, Mx}, 0, '0);
      add_row({Mx, Mn, Mx, Mn, Mx, Mn, Mx, Mx, Mn}, 0, '0);
      add_row({Mn, Mx, Mn, Mx, Mn, Mx, Mn, Mn, Mx}, 0, '0);
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd1},
              0, '0);
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, -32'sd1, 32'sd1, 32'sd0},
              0, '0);
      add_row({32'sd0, 32'sd0, 32'sd0, One, 32'sd2, 32'sd0, 32'sd0, One, 32'sd3}, 0, '0);
      add_row({32'sd5, -32'sd7, 32'sd1, 32'sd10, -32'sd14, 32'sd2, 32'sd15, -32'sd21,
               32'sd3}, 1, '{0, 0, 0, 1});
      add_row({-32'sd1, -32'sd1, -32'sd1, Mx, Mn, 32'sd0, Mn, 32'sd0, Mx}, 0, '0);
      add_row({32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd4, 32'sd0, -32'sd4, 32'sd3, 32'sd0},
              1, '{0, 0, Q14One, 0});
   endfunction

   task automatic send_triangle(corners_type t, bit typed, normal_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
       req_c_x, req_c_y, req_c_z} <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_normals.push_back(typed ? want : face_normal(t));
      items_sent++;
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_triangle(rand_triangle(), 0, '0);
   endtask

   // receiver stalls, with one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
         hold_taken  <= 1'b0;
      end else if (hold_start && !hold_taken) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= HoldLength - 1;
         hold_taken  <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_stall_pct;
      end
   end

   // compare each returned normal with the oldest expectation
   always @(posedge clock) begin
      normal_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate};
         normals_seen++;
         if (rsp_degenerate) degen_seen++;
         if (expected_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected normal %p", got);
         end else begin
            want = expected_normals.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                           want.nx, want.ny, want.nz, want.degen,
                           got.nx, got.ny, got.nz, got.degen);
            end
         end
      end
   end

   // watchdog on cycles without any item moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("triangle_face_normal_test: done, errors");
            $finish;
         end
      end
   end

   // reset, stimulus phases, drain
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
       req_c_x, req_c_y, req_c_z} = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_start = 1'b0;
      items_sent = 0;
      build_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i])
         send_triangle(stim_table[i].tri_in, stim_table[i].typed, stim_table[i].want);
      send_random(330);
      send_idle_pct = 77;
      send_random(330);
      send_idle_pct = 0;
      recv_stall_pct = 77;
      send_random(330);
      send_idle_pct = 26;
      recv_stall_pct = 26;
      send_random(330);
      // long receiver hold-off while items keep coming, to back the block up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_start = 1'b1;
      send_random(110);
      req_valid <= 1'b0;

      while (expected_normals.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d triangles (directed extremes, axis and collinear cases, random)",
               items_sent);
      $display("%0d normals checked, %0d degenerate, under idle, stall and backpressure",
               normals_seen, degen_seen);
      if (mismatches == 0 && expected_normals.size() == 0)
         $display("triangle_face_normal_test: done, clean");
      else
         $display("triangle_face_normal_test: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
design/tfn_pkg.sv
design/tfn_isqrt.sv
design/tfn_qdiv.sv
design/triangle_face_normal.sv
verif/triangle_face_normal_test.sv
